// ----- src/cstps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstps_pkg
// Widths, register codes, reset values and pipeline tag for the triangle
// plane-stress stiffness core.
// ----------------------------------------------------------------------------
package cstps_pkg;

    // field and register widths
    localparam int CW     = 32;     // coordinate
    localparam int NUW    = 15;     // Poisson register
    localparam int BW     = 33;     // b and c coefficients
    localparam int PW     = 66;     // product of two coefficients
    localparam int KW     = 18;     // material matrix term
    localparam int MW     = 84;     // signed B^T D' B term
    localparam int MAGW   = 82;     // its magnitude
    localparam int LIMBW  = 32;     // multiplier limb
    localparam int TEW    = 64;     // modulus times thickness
    localparam int SW     = 128;    // partial sum per thickness limb
    localparam int NW     = 146;    // numerator before scaling
    localparam int DTW    = 67;     // signed determinant
    localparam int ADW    = 65;     // determinant magnitude
    localparam int OMNW   = 33;     // 2^32 - nu^2
    localparam int YW     = 100;    // divisor, twice the denominator
    localparam int QW     = 64;     // quotient
    localparam int OUT_FRAC_BITS = 32;
    localparam int XW     = NW + OUT_FRAC_BITS + 2;

    // stream layout
    localparam int IN_W     = 6 * CW;
    localparam int OUT_W    = 72;
    localparam int USER_W   = 2;
    localparam int ROW_LSB  = 0;
    localparam int COL_LSB  = 3;
    localparam int VAL_LSB  = 6;
    localparam int DEGEN_BIT = 0;
    localparam int SAT_BIT   = 1;

    localparam logic [2:0] LAST_DOF = 3'd5;

    localparam logic [QW-1:0] VAL_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] VAL_MIN = {1'b1, {(QW-1){1'b0}}};

    // material terms: 2^17 on the diagonal, 2^16 base of the shear term
    localparam logic [KW-1:0] K_DIAG  = 18'h20000;
    localparam logic [KW-1:0] K_SHEAR = 18'h10000;

    // configuration register codes
    typedef enum logic [1:0] {
        CFG_MODULUS   = 2'd0,
        CFG_POISSON   = 2'd1,
        CFG_THICKNESS = 2'd2
    } cfg_idx_t;

    localparam logic [31:0]    RST_MODULUS   = 32'd200000;
    localparam logic [NUW-1:0] RST_POISSON   = 15'd19661;
    localparam logic [31:0]    RST_THICKNESS = 32'd65536;

    // per-entry tag that travels down the pipeline
    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
        logic       last;
        logic       degen;
        logic       neg;
    } tag_t;

    // one divider stage
    typedef struct packed {
        tag_t            tag;
        logic            ovf;
        logic [YW-1:0]   y;
        logic [YW-1:0]   rem;
        logic [QW-1:0]   xlo;
        logic [QW-1:0]   q;
    } dstage_t;

endpackage

// ----- src/cst_plane_stress_stiffness_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_plane_stress_stiffness_core
// Constant-strain triangle stiffness, plane stress: one triangle in, the
// 36 entries of t*A*B^T*D*B out in row-major order, Q32.32, saturated.
// ----------------------------------------------------------------------------
//  channel  | direction | request
//  s_*      | in        | six Q16.16 vertex coordinates
//  m_*      | out       | one stiffness entry with row, column and flags
//  cfg_*    | in        | register write (index, data)
//
//  A triangle occupies the entry sequencer for its 36 entries, one entry a
//  cycle while m_tready does not stall; the next triangle is taken during the
//  last of them. Each entry passes the operand stages, the 64-stage restoring
//  divider for the rounded quotient and the output register.
//  Reset clears valid bits and restores the reset configuration; a stall on
//  m_tready freezes the whole pipeline, nothing is lost or repeated.
// ----------------------------------------------------------------------------
module cst_plane_stress_stiffness_core
    import cstps_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // node0_x, node0_y, node1_x, node1_y, node2_x, node2_y
    input  logic [IN_W-1:0]   s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // row_index[2:0], col_index[5:3], stiffness_value[69:6], zero pad
    output logic [OUT_W-1:0]  m_tdata,
    // degenerate[0], saturated[1]
    output logic [USER_W-1:0] m_tuser,
    output logic              m_tlast,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [31:0]     modulus_reg;
    logic [NUW-1:0]  poisson_reg;
    logic [31:0]     thickness_reg;
    logic [TEW-1:0]  te_reg;
    logic [OMNW-1:0] omn_reg;
    logic [2*NUW-1:0] nsq;

    assign cfg_ready = 1'b1;

    // take register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg   <= RST_MODULUS;
            poisson_reg   <= RST_POISSON;
            thickness_reg <= RST_THICKNESS;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MODULUS:   modulus_reg   <= cfg_data;
                CFG_POISSON:   poisson_reg   <= cfg_data[NUW-1:0];
                CFG_THICKNESS: thickness_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // derive per-configuration constants
    assign nsq = (2*NUW)'(poisson_reg) * (2*NUW)'(poisson_reg);
    always_ff @(posedge aclk) begin
        te_reg  <= TEW'(modulus_reg) * TEW'(thickness_reg);
        omn_reg <= {1'b1, 32'b0} - {3'b0, nsq};
    end

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    logic adv;
    logic out_v_reg;
    assign adv = !out_v_reg || m_tready;

    // ------------------------------------------------------------------
    // input decode: b and c coefficients
    // ------------------------------------------------------------------
    logic signed [CW-1:0] x0, y0, x1, y1, x2, y2;
    logic signed [BW-1:0] b_in [3];
    logic signed [BW-1:0] c_in [3];

    assign x0 = $signed(s_tdata[0*CW +: CW]);
    assign y0 = $signed(s_tdata[1*CW +: CW]);
    assign x1 = $signed(s_tdata[2*CW +: CW]);
    assign y1 = $signed(s_tdata[3*CW +: CW]);
    assign x2 = $signed(s_tdata[4*CW +: CW]);
    assign y2 = $signed(s_tdata[5*CW +: CW]);

    assign b_in[0] = BW'(y1) - BW'(y2);
    assign c_in[0] = BW'(x2) - BW'(x1);
    assign b_in[1] = BW'(y2) - BW'(y0);
    assign c_in[1] = BW'(x0) - BW'(x2);
    assign b_in[2] = BW'(y0) - BW'(y1);
    assign c_in[2] = BW'(x1) - BW'(x0);

    // ------------------------------------------------------------------
    // entry sequencer
    // ------------------------------------------------------------------
    logic                 seq_v_reg;
    logic [2:0]           row_reg, col_reg;
    logic signed [BW-1:0] b_reg [3];
    logic signed [BW-1:0] c_reg [3];
    logic                 issue, seq_last, s_acc;

    assign seq_last = (row_reg == LAST_DOF) && (col_reg == LAST_DOF);
    assign issue    = seq_v_reg && adv;
    assign s_tready = !seq_v_reg || (issue && seq_last);
    assign s_acc    = s_tvalid && s_tready;

    // advance row and column over the 36 entries
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_v_reg <= 1'b0;
            row_reg   <= '0;
            col_reg   <= '0;
        end else if (s_acc) begin
            seq_v_reg <= 1'b1;
            row_reg   <= '0;
            col_reg   <= '0;
        end else if (issue && seq_last) begin
            seq_v_reg <= 1'b0;
        end else if (issue) begin
            if (col_reg == LAST_DOF) begin
                col_reg <= '0;
                row_reg <= row_reg + 3'd1;
            end else begin
                col_reg <= col_reg + 3'd1;
            end
        end
    end

    // hold the triangle coefficients
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            for (int p = 0; p < 3; p++) begin
                b_reg[p] <= b_in[p];
                c_reg[p] <= c_in[p];
            end
        end
    end

    // pick operands: M = u1*v1*k1 + u2*v2*k2
    logic [1:0]           rn, cn;
    logic signed [BW-1:0] bp, cp, bq, cq;
    logic signed [BW-1:0] op [4];
    logic [KW-1:0]        k1, k_cross, k_shear;

    assign rn = row_reg[2:1];
    assign cn = col_reg[2:1];
    assign bp = b_reg[rn];
    assign cp = c_reg[rn];
    assign bq = b_reg[cn];
    assign cq = c_reg[cn];
    assign k_cross = {2'b0, poisson_reg, 1'b0};
    assign k_shear = K_SHEAR - {3'b0, poisson_reg};

    always_comb begin
        case ({row_reg[0], col_reg[0]})
            2'b00: begin
                op[0] = bp; op[1] = bq; op[2] = cp; op[3] = cq; k1 = K_DIAG;
            end
            2'b01: begin
                op[0] = bp; op[1] = cq; op[2] = cp; op[3] = bq; k1 = k_cross;
            end
            2'b10: begin
                op[0] = cp; op[1] = bq; op[2] = bp; op[3] = cq; k1 = k_cross;
            end
            default: begin
                op[0] = cp; op[1] = cq; op[2] = bp; op[3] = bq; k1 = K_DIAG;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // stage 1: operands
    // ------------------------------------------------------------------
    logic                 s1_v_reg;
    tag_t                 s1_tag_reg;
    logic signed [BW-1:0] s1_op_reg [4];
    logic signed [BW-1:0] s1_dt_reg [4];
    logic [KW-1:0]        s1_k1_reg, s1_k2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) s1_v_reg <= 1'b0;
        else if (adv) s1_v_reg <= seq_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_tag_reg <= '{row: row_reg, col: col_reg, last: seq_last,
                            degen: 1'b0, neg: 1'b0};
            for (int i = 0; i < 4; i++) s1_op_reg[i] <= op[i];
            s1_dt_reg[0] <= c_reg[2];
            s1_dt_reg[1] <= b_reg[1];
            s1_dt_reg[2] <= c_reg[1];
            s1_dt_reg[3] <= b_reg[2];
            s1_k1_reg <= k1;
            s1_k2_reg <= k_shear;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: coefficient products
    // ------------------------------------------------------------------
    logic                 s2_v_reg;
    tag_t                 s2_tag_reg;
    logic signed [PW-1:0] s2_p1_reg, s2_p2_reg, s2_q1_reg, s2_q2_reg;
    logic [KW-1:0]        s2_k1_reg, s2_k2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) s2_v_reg <= 1'b0;
        else if (adv) s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_tag_reg <= s1_tag_reg;
            s2_p1_reg  <= PW'(s1_op_reg[0]) * PW'(s1_op_reg[1]);
            s2_p2_reg  <= PW'(s1_op_reg[2]) * PW'(s1_op_reg[3]);
            s2_q1_reg  <= PW'(s1_dt_reg[0]) * PW'(s1_dt_reg[1]);
            s2_q2_reg  <= PW'(s1_dt_reg[2]) * PW'(s1_dt_reg[3]);
            s2_k1_reg  <= s1_k1_reg;
            s2_k2_reg  <= s1_k2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: scale by material terms, determinant
    // ------------------------------------------------------------------
    logic                  s3_v_reg;
    tag_t                  s3_tag_reg;
    logic signed [MW-1:0]  s3_m1_reg, s3_m2_reg;
    logic signed [DTW-1:0] s3_dt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) s3_v_reg <= 1'b0;
        else if (adv) s3_v_reg <= s2_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_tag_reg <= s2_tag_reg;
            s3_m1_reg  <= MW'(s2_p1_reg) * MW'($signed({1'b0, s2_k1_reg}));
            s3_m2_reg  <= MW'(s2_p2_reg) * MW'($signed({1'b0, s2_k2_reg}));
            s3_dt_reg  <= DTW'(s2_q1_reg) - DTW'(s2_q2_reg);
        end
    end

    // ------------------------------------------------------------------
    // stage 4: sum the terms, determinant magnitude
    // ------------------------------------------------------------------
    logic                  s4_v_reg;
    tag_t                  s4_tag_reg;
    logic signed [MW-1:0]  s4_m_reg;
    logic [ADW-1:0]        s4_dtabs_reg;
    logic signed [DTW-1:0] dt_neg;
    tag_t                  s4_tag_next;

    assign dt_neg = -s3_dt_reg;
    always_comb begin
        s4_tag_next       = s3_tag_reg;
        s4_tag_next.degen = (s3_dt_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) s4_v_reg <= 1'b0;
        else if (adv) s4_v_reg <= s3_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_tag_reg   <= s4_tag_next;
            s4_m_reg     <= s3_m1_reg + s3_m2_reg;
            s4_dtabs_reg <= s3_dt_reg[DTW-1] ? dt_neg[ADW-1:0] : s3_dt_reg[ADW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // stage 5: magnitude of M, denominator products
    // ------------------------------------------------------------------
    logic                 s5_v_reg;
    tag_t                 s5_tag_reg;
    logic [MAGW-1:0]      s5_mabs_reg;
    logic [OMNW+31:0]     s5_pa_reg;
    logic [OMNW+32:0]     s5_pb_reg;
    logic signed [MW-1:0] m_neg;
    tag_t                 s5_tag_next;

    assign m_neg = -s4_m_reg;
    always_comb begin
        s5_tag_next     = s4_tag_reg;
        s5_tag_next.neg = s4_m_reg[MW-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) s5_v_reg <= 1'b0;
        else if (adv) s5_v_reg <= s4_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s5_tag_reg  <= s5_tag_next;
            s5_mabs_reg <= s4_m_reg[MW-1] ? m_neg[MAGW-1:0] : s4_m_reg[MAGW-1:0];
            s5_pa_reg   <= (OMNW+32)'(omn_reg) * (OMNW+32)'(s4_dtabs_reg[31:0]);
            s5_pb_reg   <= (OMNW+33)'(omn_reg) * (OMNW+33)'(s4_dtabs_reg[ADW-1:32]);
        end
    end

    // ------------------------------------------------------------------
    // stage 6: numerator partial products, divisor
    // ------------------------------------------------------------------
    logic                 s6_v_reg;
    tag_t                 s6_tag_reg;
    logic [2*LIMBW-1:0]   s6_pp_reg [3][2];
    logic [YW-1:0]        s6_y_reg;
    logic [3*LIMBW-1:0]   mpad;
    logic [OMNW+64:0]     den_full;

    assign mpad     = {{(3*LIMBW-MAGW){1'b0}}, s5_mabs_reg};
    assign den_full = {s5_pb_reg, 32'b0} + {33'b0, s5_pa_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) s6_v_reg <= 1'b0;
        else if (adv) s6_v_reg <= s5_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s6_tag_reg <= s5_tag_reg;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 2; j++) begin
                    s6_pp_reg[i][j] <= (2*LIMBW)'(mpad[i*LIMBW +: LIMBW])
                                     * (2*LIMBW)'(te_reg[j*LIMBW +: LIMBW]);
                end
            end
            s6_y_reg <= {den_full[YW-4:0], 3'b0};
        end
    end

    // ------------------------------------------------------------------
    // stage 7: sum partial products per thickness limb
    // ------------------------------------------------------------------
    logic          s7_v_reg;
    tag_t          s7_tag_reg;
    logic [SW-1:0] s7_s_reg [2];
    logic [YW-1:0] s7_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) s7_v_reg <= 1'b0;
        else if (adv) s7_v_reg <= s6_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s7_tag_reg <= s6_tag_reg;
            s7_y_reg   <= s6_y_reg;
            for (int j = 0; j < 2; j++) begin
                s7_s_reg[j] <= {64'b0, s6_pp_reg[0][j]}
                             + {32'b0, s6_pp_reg[1][j], 32'b0}
                             + {s6_pp_reg[2][j], 64'b0};
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 8: full numerator
    // ------------------------------------------------------------------
    logic            s8_v_reg;
    tag_t            s8_tag_reg;
    logic [NW-1:0]   s8_n_reg;
    logic [YW-1:0]   s8_y_reg;
    logic [SW+31:0]  n_sum;

    assign n_sum = {32'b0, s7_s_reg[0]} + {s7_s_reg[1], 32'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) s8_v_reg <= 1'b0;
        else if (adv) s8_v_reg <= s7_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s8_tag_reg <= s7_tag_reg;
            s8_n_reg   <= n_sum[NW-1:0];
            s8_y_reg   <= s7_y_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 9: scaled dividend with half divisor for rounding
    // ------------------------------------------------------------------
    logic          s9_v_reg;
    tag_t          s9_tag_reg;
    logic [XW-1:0] s9_x_reg;
    logic [YW-1:0] s9_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) s9_v_reg <= 1'b0;
        else if (adv) s9_v_reg <= s8_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s9_tag_reg <= s8_tag_reg;
            s9_x_reg   <= XW'({s8_n_reg, {(OUT_FRAC_BITS+1){1'b0}}})
                        + XW'(s8_y_reg[YW-1:1]);
            s9_y_reg   <= s8_y_reg;
        end
    end

    // ------------------------------------------------------------------
    // divider: overflow check, then one quotient bit per stage
    // ------------------------------------------------------------------
    logic    dv_reg  [QW+1];
    dstage_t dst_reg [QW+1];
    dstage_t dst_next [QW+1];
    logic    ovf0;

    assign ovf0 = s9_x_reg[XW-1:QW] >= (XW-QW)'(s9_y_reg);

    always_comb begin
        logic [YW:0] t;
        logic [YW:0] diff;
        logic        ge;
        dst_next[0].tag = s9_tag_reg;
        dst_next[0].ovf = ovf0;
        dst_next[0].y   = s9_y_reg;
        dst_next[0].rem = ovf0 ? '0 : s9_x_reg[QW+YW-1:QW];
        dst_next[0].xlo = s9_x_reg[QW-1:0];
        dst_next[0].q   = '0;
        for (int k = 0; k < QW; k++) begin
            t    = {dst_reg[k].rem, dst_reg[k].xlo[QW-1]};
            diff = t - {1'b0, dst_reg[k].y};
            ge   = (t >= {1'b0, dst_reg[k].y});
            dst_next[k+1]     = dst_reg[k];
            dst_next[k+1].rem = ge ? diff[YW-1:0] : t[YW-1:0];
            dst_next[k+1].xlo = {dst_reg[k].xlo[QW-2:0], 1'b0};
            dst_next[k+1].q   = {dst_reg[k].q[QW-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= QW; k++) dv_reg[k] <= 1'b0;
        end else if (adv) begin
            dv_reg[0] <= s9_v_reg;
            for (int k = 0; k < QW; k++) dv_reg[k+1] <= dv_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k <= QW; k++) dst_reg[k] <= dst_next[k];
        end
    end

    // ------------------------------------------------------------------
    // output: sign, saturation, degenerate zero
    // ------------------------------------------------------------------
    logic [2:0]    out_row_reg, out_col_reg;
    logic [QW-1:0] out_val_reg;
    logic          out_degen_reg, out_sat_reg, out_last_reg;
    logic [QW-1:0] fq, val_next;
    logic          sat_next;
    dstage_t       fin;

    assign fin = dst_reg[QW];
    assign fq  = fin.q;

    always_comb begin
        if (fin.tag.degen) begin
            sat_next = 1'b0;
            val_next = '0;
        end else if (!fin.tag.neg) begin
            sat_next = fin.ovf || fq[QW-1];
            val_next = sat_next ? VAL_MAX : fq;
        end else begin
            sat_next = fin.ovf || (fq[QW-1] && (fq[QW-2:0] != '0));
            val_next = sat_next ? VAL_MIN : (~fq + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) out_v_reg <= 1'b0;
        else if (adv) out_v_reg <= dv_reg[QW];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_row_reg   <= fin.tag.row;
            out_col_reg   <= fin.tag.col;
            out_last_reg  <= fin.tag.last;
            out_degen_reg <= fin.tag.degen;
            out_sat_reg   <= sat_next;
            out_val_reg   <= val_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {{(OUT_W-VAL_LSB-QW){1'b0}}, out_val_reg, out_col_reg, out_row_reg};
    assign m_tuser  = {out_sat_reg, out_degen_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ----- src/cstps_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstps_checker
// Port-level checks on the stiffness core result stream, bound to the top.
// ----------------------------------------------------------------------------
module cstps_checker
    import cstps_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [IN_W-1:0]   s_tdata,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_W-1:0]  m_tdata,
    input logic [USER_W-1:0] m_tuser,
    input logic              m_tlast,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic [1:0]        cfg_index,
    input logic [31:0]       cfg_data
);

    logic [QW-1:0] value;
    assign value = m_tdata[VAL_LSB +: QW];

    // the last entry of an element is the bottom-right corner
    a_last_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tdata[ROW_LSB +: 3] == LAST_DOF)
                             && (m_tdata[COL_LSB +: 3] == LAST_DOF))
        else $error("last entry not at row 5, column 5");

    // a degenerate element gives clean zeros
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[DEGEN_BIT] |-> (value == '0) && !m_tuser[SAT_BIT])
        else $error("degenerate entry not zero");

    // a clipped entry sits at a range limit
    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[SAT_BIT] |-> (value == VAL_MAX) || (value == VAL_MIN))
        else $error("saturated entry not at a limit");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                 && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed under stall");

endmodule

bind cst_plane_stress_stiffness_core cstps_checker u_cstps_checker (.*);

// ----- test/cst_plane_stress_stiffness_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_plane_stress_stiffness_core_tb
// Self-checking bench for the triangle stiffness core. Triangles are queued
// by the stimulus process and sent by a clocked driver. Each accepted triangle
// is run through an exact wide-integer model, which queues 36 expected
// entries. A clocked monitor compares every returned entry against them.
// Register settings change only while the core is empty. Both sides idle at
// random, and the receiver stalls once for a long stretch.
// ----------------------------------------------------------------------------
module cst_plane_stress_stiffness_core_tb;
    import cstps_pkg::*;

    localparam int NFRAC = 32;

    typedef struct {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [63:0] value;
        logic        degen;
        logic        sat;
        logic        last;
    } entry_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic [USER_W-1:0] m_tuser;
    logic              m_tlast;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = '0;
    logic [31:0]       cfg_data = '0;

    // bench copy of the registers
    logic [31:0]    modulus   = RST_MODULUS;
    logic [NUW-1:0] poisson   = RST_POISSON;
    logic [31:0]    thickness = RST_THICKNESS;

    logic [IN_W-1:0] triangle_q[$];
    entry_t          entry_q[$];
    int              tx_gap = 0;
    int              rx_gap = 0;
    bit              steady = 0;     // no sender gaps while set
    bit              rx_hold = 0;
    int              triangles_sent = 0;
    int              entries_seen = 0;
    int              degen_seen = 0;
    int              sat_seen = 0;
    int              errors = 0;

    cst_plane_stress_stiffness_core dut (.*);

    always #6 aclk = ~aclk;

    task automatic report(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        errors++;
    endtask

    // exact stiffness of one triangle, queued as 36 expected entries
    function automatic void predict_stiffness(input logic [IN_W-1:0] tri_in);
        logic signed [255:0] x[3], y[3], b[3], c[3], cv[6][3];
        logic signed [255:0] det, den, te, m, d2, nu, q;
        logic [255:0]        num, mag;
        logic                degen, neg;
        entry_t              e;
        int                  p;
        for (p = 0; p < 3; p++) begin
            x[p] = $signed(tri_in[64*p +: 32]);
            y[p] = $signed(tri_in[64*p+32 +: 32]);
        end
        for (p = 0; p < 3; p++) begin
            b[p] = y[(p+1)%3] - y[(p+2)%3];
            c[p] = x[(p+2)%3] - x[(p+1)%3];
            cv[2*p]   = '{b[p], 0, c[p]};
            cv[2*p+1] = '{0, c[p], b[p]};
        end
        nu  = poisson;
        det = (x[1]-x[0])*(y[2]-y[0]) - (x[2]-x[0])*(y[1]-y[0]);
        degen = (det == 0);
        if (det < 0) det = -det;
        den = det * ((256'sd1 <<< 32) - nu*nu) * 4;
        te  = $signed({224'd0, modulus}) * $signed({224'd0, thickness});
        d2  = den <<< 1;
        for (int i = 0; i < 6; i++) begin
            for (int j = 0; j < 6; j++) begin
                e.row = 3'(i); e.col = 3'(j); e.degen = degen; e.sat = 1'b0;
                e.last = (i == 5 && j == 5); e.value = '0;
                if (!degen) begin
                    m = cv[i][0] * (131072*cv[j][0] + 2*nu*cv[j][1])
                      + cv[i][1] * (2*nu*cv[j][0] + 131072*cv[j][1])
                      + cv[i][2] * (65536 - nu) * cv[j][2];
                    neg = (m < 0);
                    if (neg) m = -m;
                    num = ((te * m) <<< (NFRAC + 1)) + den;
                    mag = num / d2;
                    // clip to the signed 64-bit range
                    if (!neg) begin
                        if (mag > 256'h7FFF_FFFF_FFFF_FFFF) begin
                            e.sat = 1'b1; mag = 256'h7FFF_FFFF_FFFF_FFFF;
                        end
                        e.value = mag[63:0];
                    end else begin
                        if (mag > 256'h8000_0000_0000_0000) begin
                            e.sat = 1'b1; mag = 256'h8000_0000_0000_0000;
                        end
                        e.value = -mag[63:0];
                    end
                end
                entry_q.push_back(e);
            end
        end
    endfunction

    function automatic logic [IN_W-1:0] pack_tri(input int x0, y0, x1, y1, x2, y2);
        return {y2, x2, y1, x1, y0, x0};
    endfunction

    // mostly small well-shaped triangles, some full-range, flat or tiny ones
    function automatic logic [IN_W-1:0] random_tri();
        int kind, bx, by;
        logic [IN_W-1:0] t;
        kind = $urandom_range(0, 9);
        bx = int'($urandom_range(0, 2**21)) - 2**20;
        by = int'($urandom_range(0, 2**21)) - 2**20;
        case (kind)
            6, 7: begin
                for (int k = 0; k < 6; k++) t[32*k +: 32] = $urandom;
            end
            8: begin
                t = pack_tri(bx, by, bx + 3000, by - 700, bx + 6000, by - 1400);
                if ($urandom_range(0, 1)) t[191:128] = t[127:64];
            end
            9: t = pack_tri(bx, by, bx + $urandom_range(0, 3), by + $urandom_range(0, 3),
                            bx + $urandom_range(0, 3), by + $urandom_range(0, 3));
            default: t = pack_tri(bx, by,
                bx + int'($urandom_range(0, 2**19)) - 2**18,
                by + int'($urandom_range(0, 2**19)) - 2**18,
                bx + int'($urandom_range(0, 2**19)) - 2**18,
                by + int'($urandom_range(0, 2**19)) - 2**18);
        endcase
        return t;
    endfunction

    // send triangles; predict on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_stiffness(s_tdata);
                triangles_sent++;
            end
            if (s_tvalid && !s_tready) begin
                // hold the current request
            end else if (tx_gap > 0) begin
                tx_gap   <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end else if (triangle_q.size() > 0) begin
                s_tdata  <= triangle_q.pop_front();
                s_tvalid <= 1'b1;
                tx_gap   <= (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // check entries; draw receiver stalls
    always @(posedge aclk) begin
        entry_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                entries_seen++;
                if (entry_q.size() == 0) begin
                    report("entry arrived with none expected");
                end else begin
                    e = entry_q.pop_front();
                    if (m_tuser[DEGEN_BIT]) degen_seen++;
                    if (m_tuser[SAT_BIT]) sat_seen++;
                    if (m_tdata[ROW_LSB +: 3] !== e.row || m_tdata[COL_LSB +: 3] !== e.col ||
                        m_tdata[VAL_LSB +: 64] !== e.value || m_tuser[DEGEN_BIT] !== e.degen ||
                        m_tuser[SAT_BIT] !== e.sat || m_tlast !== e.last)
                        report($sformatf("K[%0d][%0d] got r%0d c%0d %h d%b s%b l%b, want %h d%b s%b l%b",
                            e.row, e.col, m_tdata[ROW_LSB +: 3], m_tdata[COL_LSB +: 3],
                            m_tdata[VAL_LSB +: 64], m_tuser[DEGEN_BIT], m_tuser[SAT_BIT],
                            m_tlast, e.value, e.degen, e.sat, e.last));
                end
            end
            if (rx_hold) begin
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap   <= rx_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_gap <= (steady || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(0, 18);
            end
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MODULUS:   modulus   = value;
            CFG_POISSON:   poisson   = value[NUW-1:0];
            CFG_THICKNESS: thickness = value;
            default: ;
        endcase
    endtask

    // wait until every queued triangle has been answered, then let the pipe drain
    task automatic drain();
        wait (triangle_q.size() == 0 && !s_tvalid && entry_q.size() == 0);
        repeat (100) @(posedge aclk);
    endtask

    task automatic run_random(input int count);
        repeat (count) triangle_q.push_back(random_tri());
        drain();
    endtask

    // stimulus and configuration phases
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed triangles at reset settings
        triangle_q.push_back(pack_tri(0, 0, 65536, 0, 0, 65536));
        triangle_q.push_back(pack_tri(0, 0, 0, 65536, 65536, 0));
        triangle_q.push_back(pack_tri(0, 0, 0, 0, 0, 0));
        triangle_q.push_back(pack_tri(0, 0, 65536, 65536, 131072, 131072));
        triangle_q.push_back(pack_tri(-2147483648, -2147483648, 2147483647, -2147483648,
                                      -2147483648, 2147483647));
        triangle_q.push_back(pack_tri(2147483647, 2147483647, -2147483648, 2147483647,
                                      2147483647, -2147483648));
        triangle_q.push_back({6{32'h7FFF_FFFF}});
        triangle_q.push_back({6{32'h8000_0000}});
        triangle_q.push_back(pack_tri(0, 0, 1, 0, 0, 1));
        triangle_q.push_back(pack_tri(-1, -1, 0, 0, -1, 0));
        triangle_q.push_back(pack_tri(100000, -300000, -250000, 70000, 90000, 410000));
        triangle_q.push_back({32'hFFFF_FFFF, 32'h0, 32'hAAAA_AAAA, 32'h5555_5555,
                              32'h0000_FFFF, 32'hFFFF_0000});
        drain();

        // maximum material and thickness
        write_reg(CFG_MODULUS, 32'hFFFF_FFFF);
        write_reg(CFG_POISSON, 32'hFFFF_FFFF);
        write_reg(CFG_THICKNESS, 32'hFFFF_FFFF);
        triangle_q.push_back(pack_tri(0, 0, 65536, 0, 0, 65536));
        triangle_q.push_back(pack_tri(0, 0, 1, 0, 0, 1));
        triangle_q.push_back(pack_tri(-2147483648, -2147483648, 2147483647, -2147483648,
                                      -2147483648, 2147483647));
        run_random(35);

        // reset settings, back-to-back requests while the receiver holds off
        write_reg(CFG_MODULUS, RST_MODULUS);
        write_reg(CFG_POISSON, RST_POISSON);
        write_reg(CFG_THICKNESS, RST_THICKNESS);
        steady = 1;
        fork
            run_random(40);
            begin
                wait (triangles_sent >= 60);
                rx_hold = 1;
                repeat (600) @(posedge aclk);
                rx_hold = 0;
            end
        join
        steady = 0;

        // zero modulus, zero Poisson ratio, minimal thickness
        write_reg(CFG_MODULUS, 32'd0);
        write_reg(CFG_POISSON, 32'd0);
        run_random(20);
        write_reg(CFG_MODULUS, 32'd1);
        write_reg(CFG_THICKNESS, 32'd1);
        run_random(25);
        write_reg(CFG_THICKNESS, 32'd0);
        run_random(10);

        // random settings
        repeat (3) begin
            write_reg(CFG_MODULUS, $urandom);
            write_reg(CFG_POISSON, $urandom);
            write_reg(CFG_THICKNESS, $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 2**20));
            run_random(25);
        end

        $display("Covered %0d triangles and %0d entries (%0d degenerate, %0d clipped)",
                 triangles_sent, entries_seen, degen_seen, sat_seen);
        $display("over reset, extreme, zero and random register settings.");
        if (errors == 0 && entry_q.size() == 0)
            $display("cst_plane_stress_stiffness_core: match");
        else
            $display("cst_plane_stress_stiffness_core: mismatch");
        $finish;
    end

    // run limit
    initial begin
        #30_000_000;
        $display("timeout with %0d entries outstanding", entry_q.size());
        $display("cst_plane_stress_stiffness_core: mismatch");
        $finish;
    end

endmodule

// ----- cst_plane_stress_stiffness_core.f -----
src/cstps_pkg.sv
src/cst_plane_stress_stiffness_core.sv
src/cstps_checker.sv
test/cst_plane_stress_stiffness_core_tb.sv
